/* src/anb_pkg.sv */
// shared types and constants for the annex b to length-prefixed nal splitter
`default_nettype none
package anb_pkg;

	// longest held zero run, excess zeros are dropped and flagged
	localparam int ZERO_RUN_MAX = 15;
	localparam int ZRW          = $clog2(ZERO_RUN_MAX + 1);
	localparam int LEN_W        = 32;

	localparam logic [7:0] ZERO_BYTE  = 8'h00;
	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_LENGTH  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_ZERO_LOST = 2'd1,
		ERR_LEN_SAT   = 2'd2
	} err_t;

	// input word: one stream byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_word_t;

	// output word: payload byte or unit length
	typedef struct packed {
		logic             kind;
		logic [LEN_W-1:0] value;
		logic             last;
		logic [1:0]       error_code;
	} out_word_t;

	// list of results one input byte causes, in emit order
	typedef struct packed {
		logic             notice;
		logic [ZRW-1:0]   zcnt;
		logic             pay;
		logic [7:0]       pay_byte;
		logic             len;
		logic [LEN_W-1:0] len_val;
		logic             len0;
	} plan_t;

	// handshake between decoder and emitter
	typedef struct packed {
		logic  valid;
		plan_t plan;
	} plan_req_t;

endpackage
`default_nettype wire

/* src/anb_decode.sv */
// stream state tracking and per-byte result planning
`default_nettype none
module anb_decode import anb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      byte_valid,
	input  wire in_word_t  byte_word,
	input  wire logic      busy,
	output plan_req_t      req
);

	logic [ZRW-1:0]   zr_q;
	logic             inside_q;
	logic [LEN_W-1:0] ul_q;

	logic [ZRW-1:0]   zr_nx;
	logic             inside_nx;
	logic [LEN_W-1:0] ul_nx;
	logic [ZRW-1:0]   zr_inc;
	logic [ZRW:0]     add_cnt;
	logic [LEN_W:0]   sum;
	logic [LEN_W-1:0] sat_len;
	logic             accept;
	logic             is_zero;
	logic             is_start;
	plan_t            plan;

	assign accept   = byte_valid && !busy;
	assign is_zero  = byte_word.data_byte == ZERO_BYTE;
	assign is_start = (byte_word.data_byte == START_BYTE) && (zr_q >= ZRW'(2));

	// zero count after this byte, held at the limit
	assign zr_inc = (zr_q != ZRW'(ZERO_RUN_MAX)) ? zr_q + ZRW'(1) : zr_q;

	// length after releasing held zeros and the byte itself
	assign add_cnt = is_zero ? {1'b0, zr_inc} : {1'b0, zr_q} + (ZRW+1)'(1);
	assign sum     = {1'b0, ul_q} + (LEN_W+1)'(add_cnt);
	assign sat_len = sum[LEN_W] ? LEN_SAT : sum[LEN_W-1:0];

	// plan results and next state
	always_comb begin
		plan      = '0;
		zr_nx     = zr_q;
		inside_nx = inside_q;
		ul_nx     = ul_q;
		plan.pay_byte = byte_word.data_byte;
		if (is_zero) begin
			zr_nx       = zr_inc;
			plan.notice = inside_q && (zr_q == ZRW'(ZERO_RUN_MAX));
			if (byte_word.end_of_stream && inside_q) begin
				plan.zcnt    = zr_inc;
				plan.len     = 1'b1;
				plan.len_val = sat_len;
			end
		end else if (is_start) begin
			plan.len     = inside_q;
			plan.len_val = ul_q;
			plan.len0    = byte_word.end_of_stream;
			inside_nx    = 1'b1;
			ul_nx        = '0;
			zr_nx        = '0;
		end else begin
			if (inside_q) begin
				plan.zcnt    = zr_q;
				plan.pay     = 1'b1;
				plan.len     = byte_word.end_of_stream;
				plan.len_val = sat_len;
				ul_nx        = sat_len;
			end
			zr_nx = '0;
		end
		if (byte_word.end_of_stream) begin
			zr_nx     = '0;
			inside_nx = 1'b0;
			ul_nx     = '0;
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_q     <= '0;
			inside_q <= 1'b0;
			ul_q     <= '0;
		end else if (accept) begin
			zr_q     <= zr_nx;
			inside_q <= inside_nx;
			ul_q     <= ul_nx;
		end
	end

	assign req.valid = accept;
	assign req.plan  = plan;

`ifndef SYNTHESIS
	// held zero count never passes the limit
	a_zr_limit: assert property (@(posedge clk) disable iff (!arst_n)
		zr_q <= ZRW'(ZERO_RUN_MAX))
		else $error("zero run above limit");

	// end of stream returns the stream state to reset values
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		accept && byte_word.end_of_stream |=> zr_q == '0 && !inside_q && ul_q == '0)
		else $error("state not cleared after end of stream");
`endif

endmodule
`default_nettype wire

/* src/anb_emit.sv */
// result sequencer and output register
`default_nettype none
module anb_emit import anb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire plan_req_t req,
	output logic           busy,
	output logic           res_valid,
	input  wire logic      res_stall,
	output out_word_t      res_word
);

	logic      work_valid_s1;
	plan_t     work_s1;
	plan_t     work_nx;
	out_word_t cur;
	out_word_t res_q;
	logic      res_valid_q;
	logic      pending;
	logic      rest_pending;
	logic      out_load;
	logic      done;

	assign pending = work_s1.notice || (work_s1.zcnt != '0) || work_s1.pay ||
		work_s1.len || work_s1.len0;

	// pick the first pending result and strike it from the list
	always_comb begin
		work_nx  = work_s1;
		cur      = '0;
		if (work_s1.notice) begin
			cur.kind       = KIND_PAYLOAD;
			cur.error_code = ERR_ZERO_LOST;
			work_nx.notice = 1'b0;
		end else if (work_s1.zcnt != '0) begin
			cur.kind     = KIND_PAYLOAD;
			work_nx.zcnt = work_s1.zcnt - ZRW'(1);
		end else if (work_s1.pay) begin
			cur.kind    = KIND_PAYLOAD;
			cur.value   = LEN_W'(work_s1.pay_byte);
			work_nx.pay = 1'b0;
		end else if (work_s1.len) begin
			cur.kind       = KIND_LENGTH;
			cur.value      = work_s1.len_val;
			cur.error_code = (work_s1.len_val == LEN_SAT) ? ERR_LEN_SAT : ERR_NONE;
			work_nx.len    = 1'b0;
		end else begin
			cur.kind     = KIND_LENGTH;
			work_nx.len0 = 1'b0;
		end
		rest_pending = work_nx.notice || (work_nx.zcnt != '0) || work_nx.pay ||
			work_nx.len || work_nx.len0;
		cur.last = !rest_pending;
	end

	assign out_load = work_valid_s1 && pending && (!res_valid_q || !res_stall);
	assign done     = work_valid_s1 && (!pending || (out_load && !rest_pending));
	assign busy     = work_valid_s1 && !done;

	// work register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_s1 <= 1'b0;
		end else if (req.valid) begin
			work_valid_s1 <= 1'b1;
		end else if (done) begin
			work_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			work_s1 <= req.plan;
		end else if (out_load) begin
			work_s1 <= work_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= cur;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

`ifndef SYNTHESIS
	// a new word only arrives once the previous list is finished
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid |-> !work_valid_s1 || done)
		else $error("plan overwritten before done");

	// loss notices are zero-valued payload words
	a_notice_form: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.error_code == ERR_ZERO_LOST |->
			res_q.kind == KIND_PAYLOAD && res_q.value == '0)
		else $error("malformed loss notice");

	// payload words never carry the length flag
	a_pay_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind == KIND_PAYLOAD |-> res_q.error_code != ERR_LEN_SAT)
		else $error("length flag on payload word");
`endif

endmodule
`default_nettype wire

/* src/annexb_nal_to_length_prefixed.sv */
// a byte's results pass through the work register and then the output register
// throughput: one byte per cycle while each byte yields at most one result and res_stall is low
// a byte yielding n results (zero release, lengths) holds the input until its last is loaded, n <= 17
// the rate is set by the single output register the result sequencer fills
// reset: arst_n clears stream state, pending work and the output valid at once
`default_nettype none
module annexb_nal_to_length_prefixed import anb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_word_t byte_word,
	output logic          res_valid,
	input  wire logic     res_stall,
	output out_word_t     res_word
);

	plan_req_t req;
	logic      busy;

	// track start codes and plan each byte's results
	anb_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_word  (byte_word),
		.busy       (busy),
		.req        (req)
	);

	// send planned results one word per cycle while the output is not stalled
	anb_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	assign byte_stall = busy;

endmodule
`default_nettype wire
